// ===== rtl/cbz_pkg.sv =====
`default_nettype none

package cbz_pkg;

   // field widths
   localparam int COORD_W   = 32;
   localparam int PARAM_W   = 17;
   localparam int POINT_W   = 32;
   localparam int TANGENT_W = 36;

   // u = 1.0 in unsigned Q1.16
   localparam logic [PARAM_W-1:0] U_ONE = 17'd65536;

   // derived widths
   localparam int DIFF_W  = COORD_W + 1;   // p(i+1) - p(i)
   localparam int SQ_W    = 33;            // c*c, c*u, u*u, at most 2^32
   localparam int TRIPLE_W = 18;           // 3*c, 3*u
   localparam int WP_W    = 49;            // point weights, at most 2^48
   localparam int WP_LO_W = 24;
   localparam int TW_W    = 34;            // tangent weights, at most 3*2^32
   localparam int TW_LO_W = 17;

endpackage : cbz_pkg

`default_nettype wire

// ===== rtl/cbz_if.sv =====
`default_nettype none

interface cbz_req_if import cbz_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] ctrl_a;
   logic signed [COORD_W-1:0] ctrl_b;
   logic signed [COORD_W-1:0] ctrl_c;
   logic signed [COORD_W-1:0] ctrl_d;
   logic        [PARAM_W-1:0] param_u;

   modport source (output valid, ctrl_a, ctrl_b, ctrl_c, ctrl_d, param_u, input ready);
   modport sink   (input valid, ctrl_a, ctrl_b, ctrl_c, ctrl_d, param_u, output ready);
endinterface : cbz_req_if

interface cbz_rsp_if import cbz_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [POINT_W-1:0]   point_coord;
   logic signed [TANGENT_W-1:0] tangent_coord;

   modport source (output valid, point_coord, tangent_coord, input ready);
   modport sink   (input valid, point_coord, tangent_coord, output ready);
endinterface : cbz_rsp_if

`default_nettype wire

// ===== rtl/cbz_split_mul.sv =====
`default_nettype none

// signed operand times unsigned weight, weight split in two halves,
// both partial products registered
module cbz_split_mul #(
   parameter int A_W  = 32,
   parameter int W_W  = 49,
   parameter int LO_W = 24
) (
   input  wire logic                        clock,
   input  wire logic                        en,
   input  wire logic signed [A_W-1:0]       a,
   input  wire logic        [W_W-1:0]       w,
   output logic signed [A_W+W_W-LO_W-1:0]   prod_hi,
   output logic signed [A_W+LO_W-1:0]       prod_lo
);

   localparam int HI_W = W_W - LO_W;

   logic signed [A_W+HI_W:0]   hi_full;
   logic signed [A_W+LO_W:0]   lo_full;
   logic signed [A_W+HI_W-1:0] hi_in, hi_ff;
   logic signed [A_W+LO_W-1:0] lo_in, lo_ff;

   assign hi_full = a * $signed({1'b0, w[W_W-1:LO_W]});
   assign lo_full = a * $signed({1'b0, w[LO_W-1:0]});
   assign hi_in   = hi_full[A_W+HI_W-1:0];
   assign lo_in   = lo_full[A_W+LO_W-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         hi_ff <= hi_in;
         lo_ff <= lo_in;
      end
   end

   assign prod_hi = hi_ff;
   assign prod_lo = lo_ff;

endmodule : cbz_split_mul

`default_nettype wire

// ===== rtl/cubic_bezier_point_and_tangent_unit.sv =====
`default_nettype none

// cubic bezier point and tangent, one coordinate axis per transaction
//
// req carries one axis of the four control points (signed q16.16) and the
// parameter u (unsigned q1.16, 65536 = 1.0, larger values clamp to 1.0).
// rsp returns that axis of the curve point (32 bits, signed q16.16) and of
// the first derivative (36 bits, signed q20.16), both rounded half up.
// three axes go as three independent transactions.
//
// six register stages: clamp and differences, squares, bernstein weights,
// split partial products, partial sums, final add and rounding.
// rsp valid is the last stage's valid bit, so a transaction passes every
// stage in order before rsp takes it; one is accepted per cycle while
// req.ready is high, set by the per-stage multiplier lanes.
// each stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so empty stages fill while rsp is stalled and nothing is
// dropped or repeated; req.ready falls only when every stage is full.
// reset (synchronous, active high) clears the valid bits; payload registers
// are not reset.
module cubic_bezier_point_and_tangent_unit import cbz_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cbz_req_if.sink   req,
   cbz_rsp_if.source rsp
);

   localparam int STAGES = 6;

   // stage advance enables, en[STAGES+1] is the downstream ready
   logic [STAGES+1:1] en;
   logic [STAGES:1]   vld_in, vld_ff;

   always_comb begin
      en[STAGES+1] = rsp.ready;
      for (int k = STAGES; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = vld_ff;
      if (en[1]) begin
         vld_in[1] = req.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req.ready = en[1];

   // stage 1: clamp u, form c = 1 - u and control point differences
   logic [PARAM_W-1:0]        u_sat;
   logic [PARAM_W-1:0]        u1_ff, c1_ff;
   logic signed [COORD_W-1:0] ctrl1_ff [4];
   logic signed [DIFF_W-1:0]  diff1_ff [3];

   assign u_sat = (req.param_u > U_ONE) ? U_ONE : req.param_u;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         u1_ff       <= u_sat;
         c1_ff       <= U_ONE - u_sat;
         ctrl1_ff[0] <= req.ctrl_a;
         ctrl1_ff[1] <= req.ctrl_b;
         ctrl1_ff[2] <= req.ctrl_c;
         ctrl1_ff[3] <= req.ctrl_d;
         diff1_ff[0] <= DIFF_W'(req.ctrl_b) - DIFF_W'(req.ctrl_a);
         diff1_ff[1] <= DIFF_W'(req.ctrl_c) - DIFF_W'(req.ctrl_b);
         diff1_ff[2] <= DIFF_W'(req.ctrl_d) - DIFF_W'(req.ctrl_c);
      end
   end

   // stage 2: c^2, c*u, u^2 and the factor-three terms
   logic [2*PARAM_W-1:0]      cc_full, cu_full, uu_full;
   logic [SQ_W-1:0]           cc2_ff, cu2_ff, uu2_ff;
   logic [PARAM_W-1:0]        u2_ff, c2_ff;
   logic [TRIPLE_W-1:0]       c3x2_ff, u3x2_ff;
   logic signed [COORD_W-1:0] ctrl2_ff [4];
   logic signed [DIFF_W-1:0]  diff2_ff [3];

   assign cc_full = c1_ff * c1_ff;
   assign cu_full = c1_ff * u1_ff;
   assign uu_full = u1_ff * u1_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         cc2_ff   <= cc_full[SQ_W-1:0];
         cu2_ff   <= cu_full[SQ_W-1:0];
         uu2_ff   <= uu_full[SQ_W-1:0];
         u2_ff    <= u1_ff;
         c2_ff    <= c1_ff;
         c3x2_ff  <= {1'b0, c1_ff} + {c1_ff, 1'b0};
         u3x2_ff  <= {1'b0, u1_ff} + {u1_ff, 1'b0};
         ctrl2_ff <= ctrl1_ff;
         diff2_ff <= diff1_ff;
      end
   end

   // stage 3: bernstein weights c^3, 3c^2u, 3cu^2, u^3 (q1.48) and
   // tangent weights 3c^2, 6cu, 3u^2 (q2.32)
   logic [SQ_W+PARAM_W-1:0]     wp0_full, wp3_full;
   logic [SQ_W+TRIPLE_W-1:0]    wp1_full, wp2_full;
   logic [SQ_W+2:0]             tw1_full;
   logic [WP_W-1:0]             wp3_ff [4];
   logic [TW_W-1:0]             tw3_ff [3];
   logic signed [COORD_W-1:0]   ctrl3_ff [4];
   logic signed [DIFF_W-1:0]    diff3_ff [3];

   assign wp0_full = cc2_ff * c2_ff;
   assign wp1_full = cu2_ff * c3x2_ff;
   assign wp2_full = cu2_ff * u3x2_ff;
   assign wp3_full = uu2_ff * u2_ff;
   assign tw1_full = {2'b00, cu2_ff, 1'b0} + {1'b0, cu2_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (en[3]) begin
         wp3_ff[0] <= wp0_full[WP_W-1:0];
         wp3_ff[1] <= wp1_full[WP_W-1:0];
         wp3_ff[2] <= wp2_full[WP_W-1:0];
         wp3_ff[3] <= wp3_full[WP_W-1:0];
         tw3_ff[0] <= {1'b0, cc2_ff} + {cc2_ff, 1'b0};
         tw3_ff[1] <= tw1_full[TW_W-1:0];
         tw3_ff[2] <= {1'b0, uu2_ff} + {uu2_ff, 1'b0};
         ctrl3_ff  <= ctrl2_ff;
         diff3_ff  <= diff2_ff;
      end
   end

   // stage 4: split partial products, registered inside the lanes
   localparam int PH_W = COORD_W + WP_W - WP_LO_W;
   localparam int PL_W = COORD_W + WP_LO_W;
   localparam int TH_W = DIFF_W + TW_W - TW_LO_W;
   localparam int TL_W = DIFF_W + TW_LO_W;

   logic signed [PH_W-1:0] pp_hi [4];
   logic signed [PL_W-1:0] pp_lo [4];
   logic signed [TH_W-1:0] tp_hi [3];
   logic signed [TL_W-1:0] tp_lo [3];

   for (genvar i = 0; i < 4; i++) begin : g_point_lane
      cbz_split_mul #(
         .A_W  (COORD_W),
         .W_W  (WP_W),
         .LO_W (WP_LO_W)
      ) u_mul (
         .clock   (clock),
         .en      (en[4]),
         .a       (ctrl3_ff[i]),
         .w       (wp3_ff[i]),
         .prod_hi (pp_hi[i]),
         .prod_lo (pp_lo[i])
      );
   end

   for (genvar i = 0; i < 3; i++) begin : g_tangent_lane
      cbz_split_mul #(
         .A_W  (DIFF_W),
         .W_W  (TW_W),
         .LO_W (TW_LO_W)
      ) u_mul (
         .clock   (clock),
         .en      (en[4]),
         .a       (diff3_ff[i]),
         .w       (tw3_ff[i]),
         .prod_hi (tp_hi[i]),
         .prod_lo (tp_lo[i])
      );
   end

   // stage 5: sum the high and low halves separately
   localparam int PHS_W = PH_W + 2;
   localparam int PLS_W = PL_W + 2;
   localparam int THS_W = TH_W + 2;
   localparam int TLS_W = TL_W + 2;

   logic signed [PHS_W-1:0] phs_ff;
   logic signed [PLS_W-1:0] pls_ff;
   logic signed [THS_W-1:0] ths_ff;
   logic signed [TLS_W-1:0] tls_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         phs_ff <= PHS_W'(pp_hi[0]) + PHS_W'(pp_hi[1]) + PHS_W'(pp_hi[2])
                 + PHS_W'(pp_hi[3]);
         pls_ff <= PLS_W'(pp_lo[0]) + PLS_W'(pp_lo[1]) + PLS_W'(pp_lo[2])
                 + PLS_W'(pp_lo[3]);
         ths_ff <= THS_W'(tp_hi[0]) + THS_W'(tp_hi[1]) + THS_W'(tp_hi[2]);
         tls_ff <= TLS_W'(tp_lo[0]) + TLS_W'(tp_lo[1]) + TLS_W'(tp_lo[2]);
      end
   end

   // stage 6: recombine, add one half lsb and drop the fraction
   localparam int PT_SUM_W = 84;
   localparam int TG_SUM_W = 72;
   localparam logic signed [PT_SUM_W-1:0] PT_HALF = 84'sh800000000000;  // 2^47
   localparam logic signed [TG_SUM_W-1:0] TG_HALF = 72'sh80000000;      // 2^31

   logic signed [PT_SUM_W-1:0]  pt_sum;
   logic signed [TG_SUM_W-1:0]  tg_sum;
   logic signed [POINT_W-1:0]   point_in, point_ff;
   logic signed [TANGENT_W-1:0] tangent_in, tangent_ff;

   assign pt_sum = (PT_SUM_W'(phs_ff) <<< WP_LO_W) + PT_SUM_W'(pls_ff) + PT_HALF;
   assign tg_sum = (TG_SUM_W'(ths_ff) <<< TW_LO_W) + TG_SUM_W'(tls_ff) + TG_HALF;

   // q20.64 and q24.48 sums back to q16.16 and q20.16
   assign point_in   = pt_sum[2*WP_LO_W+POINT_W-1:2*WP_LO_W];
   assign tangent_in = tg_sum[32+TANGENT_W-1:32];

   always_ff @(posedge clock) begin
      if (en[6]) begin
         point_ff   <= point_in;
         tangent_ff <= tangent_in;
      end
   end

   assign rsp.valid         = vld_ff[STAGES];
   assign rsp.point_coord   = point_ff;
   assign rsp.tangent_coord = tangent_ff;

endmodule : cubic_bezier_point_and_tangent_unit

`default_nettype wire
